/* sv/gtr_pkg.sv */
`default_nettype none

package gtr_pkg;

  localparam int unsigned GlyphCells = 35;
  localparam int unsigned GlyphCols = 5;
  localparam int unsigned CellCntW = $clog2(GlyphCells);
  localparam int unsigned ColCntW = $clog2(GlyphCols);
  localparam int unsigned PosAccW = 17;

  localparam logic [11:0] ScreenWidthReset = 12'd480;
  localparam logic [11:0] ScreenHeightReset = 12'd272;

  localparam logic [5:0] GlyphDot = 6'd36;
  localparam logic [5:0] GlyphColon = 6'd37;
  localparam logic [5:0] GlyphMinus = 6'd38;
  localparam logic [5:0] GlyphSlash = 6'd39;
  localparam logic [5:0] GlyphPercent = 6'd40;
  localparam logic [5:0] GlyphBlank = 6'd41;

  localparam logic CfgScreenWidth = 1'b0;
  localparam logic CfgScreenHeight = 1'b1;

  localparam logic ActStart = 1'b0;
  localparam logic ActChar = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } gtr_state_t;

  typedef struct packed {
    logic load_start;
    logic load_char;
    logic step;
    logic flush_emit;
    logic cursor_adv;
  } gtr_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic hold;
    logic pend_valid;
    logic out_free;
  } gtr_status_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] folded;
    logic [5:0] idx;
    folded = code;
    idx = GlyphBlank;
    if (code >= 8'h61 && code <= 8'h7A) begin
      folded = code - 8'h20;
    end
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = 6'(code - 8'h30);
    end else if (folded >= 8'h41 && folded <= 8'h5A) begin
      idx = 6'(folded - 8'h41) + 6'd10;
    end else if (code == 8'h2E) begin
      idx = GlyphDot;
    end else if (code == 8'h3A) begin
      idx = GlyphColon;
    end else if (code == 8'h2D) begin
      idx = GlyphMinus;
    end else if (code == 8'h2F) begin
      idx = GlyphSlash;
    end else if (code == 8'h25) begin
      idx = GlyphPercent;
    end
    return idx;
  endfunction

  // Rows are packed top row first; within a row the leftmost column is the upper bit.
  function automatic logic [34:0] glyph_bits(input logic [5:0] idx);
    logic [34:0] bits;
    case (idx)
      6'd0:  bits = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd1:  bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd2:  bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd3:  bits = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd4:  bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd5:  bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd6:  bits = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd7:  bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd8:  bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd9:  bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      6'd10: bits = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd11: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd12: bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd13: bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd14: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd15: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd16: bits = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      6'd17: bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd18: bits = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd19: bits = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      6'd20: bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd21: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd22: bits = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      6'd23: bits = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd24: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd25: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd26: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd27: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd28: bits = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd29: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd30: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd31: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd32: bits = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      6'd33: bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd34: bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd35: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      6'd36: bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
      6'd37: bits = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      6'd38: bits = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      6'd39: bits = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      6'd40: bits = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

/* sv/glyph_text_rasterizer.sv */
// A start item yields no transfer on the result side.
// After a character item is accepted the input stalls while the 35 glyph cells are scanned,
// one per cycle unless a stalled square holds the scan, and while a flush state emits the
// final square, if any, and moves the cursor; the next item is accepted back in idle.
// A square is presented the cycle after the next visible lit cell is scanned, the final one
// after the flush cycle; a stalled square holds the scan at the next visible lit cell.
// The synchronous reset clears the cursor, scale and color and sets a 480 by 272 screen.
`default_nettype none

module glyph_text_rasterizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [15:0] in_start_x,
  input  wire logic [15:0] in_start_y,
  input  wire logic [7:0]  in_glyph_scale,
  input  wire logic [15:0] in_pixel_color,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_rect_x,
  output logic [11:0]      out_rect_y,
  output logic [7:0]       out_rect_width,
  output logic [7:0]       out_rect_height,
  output logic [15:0]      out_rect_color,
  output logic             out_last
);

  gtr_pkg::gtr_cmd_t    cmd;
  gtr_pkg::gtr_status_t status;

  gtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gtr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_char_code    (in_char_code),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_glyph_scale  (in_glyph_scale),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_rect_color  (out_rect_color),
    .out_last        (out_last),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

`default_nettype wire

/* sv/gtr_ctrl.sv */
`default_nettype none

module gtr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_action,
  output logic                     in_stall,
  input  wire gtr_pkg::gtr_status_t status,
  output gtr_pkg::gtr_cmd_t        cmd
);

  gtr_pkg::gtr_state_t state_r;
  gtr_pkg::gtr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      gtr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == gtr_pkg::ActStart) begin
            cmd.load_start = 1'b1;
          end else begin
            cmd.load_char = 1'b1;
            state_nxt = gtr_pkg::ST_SCAN;
          end
        end
      end
      gtr_pkg::ST_SCAN: begin
        if (!status.hold) begin
          cmd.step = 1'b1;
          if (status.last_cell) begin
            state_nxt = gtr_pkg::ST_FLUSH;
          end
        end
      end
      gtr_pkg::ST_FLUSH: begin
        if (!status.pend_valid) begin
          cmd.cursor_adv = 1'b1;
          state_nxt = gtr_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          cmd.cursor_adv = 1'b1;
          state_nxt = gtr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gtr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/gtr_datapath.sv */
`default_nettype none

module gtr_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_index,
  input  wire logic [11:0]         cfg_data,
  input  wire logic [7:0]          in_char_code,
  input  wire logic [15:0]         in_start_x,
  input  wire logic [15:0]         in_start_y,
  input  wire logic [7:0]          in_glyph_scale,
  input  wire logic [15:0]         in_pixel_color,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [11:0]              out_rect_x,
  output logic [11:0]              out_rect_y,
  output logic [7:0]               out_rect_width,
  output logic [7:0]               out_rect_height,
  output logic [15:0]              out_rect_color,
  output logic                     out_last,
  input  wire gtr_pkg::gtr_cmd_t   cmd,
  output gtr_pkg::gtr_status_t     status
);

  localparam int unsigned AccW = gtr_pkg::PosAccW;

  logic [11:0] screen_w_r;
  logic [11:0] screen_h_r;
  logic [15:0] cursor_x_r;
  logic [15:0] cursor_y_r;
  logic [7:0]  scale_r;
  logic [15:0] color_r;

  logic [34:0] glyph_r;
  logic [gtr_pkg::CellCntW-1:0] cell_r;
  logic [gtr_pkg::ColCntW-1:0]  col_r;
  logic [AccW-1:0] x_acc_r;
  logic [AccW-1:0] y_acc_r;

  logic        pend_valid_r;
  logic [11:0] pend_x_r;
  logic [11:0] pend_y_r;
  logic [7:0]  pend_w_r;
  logic [7:0]  pend_h_r;

  logic        out_valid_r;
  logic [11:0] out_x_r;
  logic [11:0] out_y_r;
  logic [7:0]  out_w_r;
  logic [7:0]  out_h_r;
  logic [15:0] out_color_r;
  logic        out_last_r;

  logic        out_free;
  logic        visible;
  logic [11:0] diff_x;
  logic [11:0] diff_y;
  logic [7:0]  cell_w;
  logic [7:0]  cell_h;
  logic        emit_pend;
  logic        hold;
  logic [10:0] advance;
  logic [16:0] adv_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign visible = glyph_r[34] && (scale_r != 8'd0)
                   && (x_acc_r < AccW'(screen_w_r))
                   && (y_acc_r < AccW'(screen_h_r));
  assign diff_x = screen_w_r - x_acc_r[11:0];
  assign diff_y = screen_h_r - y_acc_r[11:0];
  assign cell_w = (diff_x < 12'(scale_r)) ? diff_x[7:0] : scale_r;
  assign cell_h = (diff_y < 12'(scale_r)) ? diff_y[7:0] : scale_r;
  assign hold = visible && pend_valid_r && !out_free;
  assign emit_pend = (cmd.step && visible && pend_valid_r) || cmd.flush_emit;

  assign advance = {1'b0, scale_r, 2'b00} + {2'b00, scale_r, 1'b0};
  assign adv_sum = {1'b0, cursor_x_r} + 17'(advance);

  assign status.last_cell = (cell_r == gtr_pkg::CellCntW'(gtr_pkg::GlyphCells - 1));
  assign status.hold = hold;
  assign status.pend_valid = pend_valid_r;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= gtr_pkg::ScreenWidthReset;
      screen_h_r <= gtr_pkg::ScreenHeightReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gtr_pkg::CfgScreenWidth:  screen_w_r <= cfg_data;
        gtr_pkg::CfgScreenHeight: screen_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      scale_r <= '0;
      color_r <= '0;
    end else if (cmd.load_start) begin
      cursor_x_r <= in_start_x;
      cursor_y_r <= in_start_y;
      scale_r <= in_glyph_scale;
      color_r <= in_pixel_color;
    end else if (cmd.cursor_adv) begin
      cursor_x_r <= adv_sum[16] ? 16'hFFFF : adv_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      glyph_r <= gtr_pkg::glyph_bits(gtr_pkg::glyph_index(in_char_code));
      cell_r <= '0;
      col_r <= '0;
      x_acc_r <= AccW'(cursor_x_r);
      y_acc_r <= AccW'(cursor_y_r);
    end else if (cmd.step) begin
      glyph_r <= {glyph_r[33:0], 1'b0};
      cell_r <= cell_r + gtr_pkg::CellCntW'(1);
      if (col_r == gtr_pkg::ColCntW'(gtr_pkg::GlyphCols - 1)) begin
        col_r <= '0;
        x_acc_r <= AccW'(cursor_x_r);
        y_acc_r <= y_acc_r + AccW'(scale_r);
      end else begin
        col_r <= col_r + gtr_pkg::ColCntW'(1);
        x_acc_r <= x_acc_r + AccW'(scale_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.step && visible) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush_emit) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && visible) begin
      pend_x_r <= x_acc_r[11:0];
      pend_y_r <= y_acc_r[11:0];
      pend_w_r <= cell_w;
      pend_h_r <= cell_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_pend) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend) begin
      out_x_r <= pend_x_r;
      out_y_r <= pend_y_r;
      out_w_r <= pend_w_r;
      out_h_r <= pend_h_r;
      out_color_r <= color_r;
      out_last_r <= cmd.flush_emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rect_x = out_x_r;
  assign out_rect_y = out_y_r;
  assign out_rect_width = out_w_r;
  assign out_rect_height = out_h_r;
  assign out_rect_color = out_color_r;
  assign out_last = out_last_r;

endmodule

`default_nettype wire
